// ----- rtl/core/ssdn_pkg.sv -----
// Shared types, constants and fixed-point helpers for the sunrise/sunset pipeline.
`timescale 1ns / 1ps

package ssdn_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_FRAC_BITS   = 16;

    // Working width of angles and CORDIC vectors (covers pi and gain growth).
    localparam int AW        = ANGLE_FRAC_BITS + 4;
    localparam int ANG_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int RW        = 2 * AW;

    localparam longint PI_Q30       = 64'sd3373259424;
    localparam longint HALF_PI_Q30  = 64'sd1686629712;
    localparam longint GAIN_INV_Q30 = 64'sd652032874;
    localparam longint TILT_Q30     = 64'sd439273339;
    localparam longint CENTIDEG_Q30 = 64'sd187403;
    localparam longint NOON_MS      = 64'sd43200000;
    localparam longint DAY_MS       = 64'sd86400000;
    localparam int     LAT_LIMIT    = 9000;
    localparam int     LAT_RESET    = 3500;
    localparam int     EQUINOX_DOY  = 80;
    localparam int     MS_PER_S     = 1000;

    // 2*pi in Q30 = DEC_STEP_Q*365 + DEC_STEP_R; remainder divided via reciprocal.
    localparam longint DEC_STEP_Q   = 64'sd18483613;
    localparam int     DEC_STEP_R   = 103;
    localparam int     RECIP_365    = 45965;
    localparam int     RECIP_SHIFT  = 24;

    localparam longint ATAN_Q30 [0:31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    // Add half an LSB, then floor shift.
    function automatic longint asr_rnd(input longint v, input int s);
        longint r;
        if (s == 0) begin
            r = v;
        end else begin
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
        end
        return r;
    endfunction

    function automatic longint to_f(input longint v30);
        return asr_rnd(v30, ANG_SHIFT);
    endfunction

    localparam longint PI_F      = to_f(PI_Q30);
    localparam longint HALF_PI_F = to_f(HALF_PI_Q30);
    localparam longint GAIN_F    = to_f(GAIN_INV_Q30);

    // Offset estimate = round(h * NOON_MS / PI_F) by reciprocal, then one-step correction
    localparam int     HW        = $clog2(PI_F + 1);
    localparam int     OFF_SHIFT = HW + 6;
    localparam longint OFF_RECIP = ((NOON_MS <<< OFF_SHIFT) + PI_F / 2) / PI_F;

    function automatic logic signed [AW-1:0] atan_f(input int k);
        return AW'(to_f(ATAN_Q30[k]));
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } in_t;

    typedef struct packed {
        logic        is_day;
        logic [25:0] sunrise_ms;
        logic [26:0] sunset_ms;
        logic [26:0] ms_to_next_switch;
    } out_t;

endpackage

// ----- rtl/core/sunrise_sunset_day_night.sv -----
// Pipelined sunrise/sunset calculator with day flag and time to next switch.
//
//  channel  | ports                   | payload
//  ---------+-------------------------+-----------------------
//  input    | s_valid s_ready s_data  | ssdn_pkg::in_t
//  result   | m_valid m_ready m_data  | ssdn_pkg::out_t
//  config   | cfg_we cfg_wdata        | latitude, 0.01 deg
//
// One transaction per cycle unless m_ready stalls; LAT = 3*CORDIC_ITERATIONS + AW + 14 = 82
// register stages, the result valid as vld_reg[LAT-1] (three CORDIC chains and
// the square-root stages dominate; the offset takes three stages).
// aresetn (synchronous) clears valid bits and loads latitude 35.00 deg.
// All stages advance together whenever the output register is empty or being taken,
// so a stall on m_ready holds every transaction in place.
`timescale 1ns / 1ps

module sunrise_sunset_day_night (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic signed [14:0]    cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ssdn_pkg::in_t         s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ssdn_pkg::out_t        m_data
);

    localparam int AW   = ssdn_pkg::AW;
    localparam int RW   = ssdn_pkg::RW;
    localparam int IT   = ssdn_pkg::CORDIC_ITERATIONS;
    localparam int FB   = ssdn_pkg::ANGLE_FRAC_BITS;
    localparam int HW   = ssdn_pkg::HW;
    localparam int RMW  = HW + 2;
    localparam int LAT  = 3 * IT + AW + 14;

    typedef enum logic [1:0] {SEL_CALC, SEL_HALF, SEL_ZERO, SEL_PI} hsel_t;

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [16:0]    sec_reg [0:LAT-3];
    logic signed [14:0] lat_cfg_reg;

    // front stages
    logic [8:0]  s0_m_reg, s0_m_next;
    logic        s0_neg_reg, s0_neg_next, s1_neg_reg, s2_neg_reg;
    logic signed [14:0] s0_lat_reg, s0_lat_next;
    logic [16:0] sec_next;
    logic [33:0] s1_p_reg, s1_p_next;
    logic [14:0] s1_x_reg, s1_x_next;
    logic signed [32:0] s1_latp_reg, s1_latp_next;
    logic [33:0] s2_mag_reg, s2_mag_next;
    logic signed [AW-1:0] s2_lat_reg, s2_lat_next;
    logic signed [AW-1:0] s3_ang_next;

    // CORDIC 1: lane a = declination argument, lane b = latitude
    logic signed [AW-1:0] ax_reg [0:IT], ay_reg [0:IT], az_reg [0:IT];
    logic signed [AW-1:0] bx_reg [0:IT], by_reg [0:IT], bz_reg [0:IT];
    logic signed [AW-1:0] ax_next [1:IT], ay_next [1:IT], az_next [1:IT];
    logic signed [AW-1:0] bx_next [1:IT], by_next [1:IT], bz_next [1:IT];

    // CORDIC 2: declination, carrying latitude cos/sin
    logic signed [AW-1:0] cx_reg [0:IT], cy_reg [0:IT], cz_reg [0:IT];
    logic signed [AW-1:0] ccl_reg [0:IT], csl_reg [0:IT];
    logic signed [AW-1:0] cx_next [1:IT], cy_next [1:IT], cz_next [1:IT];
    logic signed [AW-1:0] dec_next, cl_next;

    logic signed [AW-1:0] f_n_reg, f_d_reg, f_n_next, f_d_next;
    logic [RW-1:0] g_d2_reg, g_n2_reg, g_d2_next, g_n2_next;
    logic signed [AW-1:0] g_n_reg;
    hsel_t g_sel_reg, g_sel_next;

    // square root stages
    logic [RW-1:0] qr_reg [0:AW], qs_reg [0:AW];
    logic [RW-1:0] qr_next [1:AW], qs_next [1:AW];
    logic signed [AW-1:0] qn_reg [0:AW];
    hsel_t qsel_reg [0:AW];

    // vectoring CORDIC
    logic signed [AW-1:0] vx_reg [0:IT], vy_reg [0:IT], vz_reg [0:IT];
    logic signed [AW-1:0] vx_next [1:IT], vy_next [1:IT], vz_next [1:IT];
    hsel_t vsel_reg [0:IT];
    logic signed [AW-1:0] v0x_next, v0y_next, v0z_next;

    logic [HW-1:0] h_reg, h_next;

    // offset: reciprocal estimate, then remainder check
    logic [26:0]           e_q_reg, e_q_next;
    logic [HW-1:0]         e_h_reg;
    logic signed [RMW-1:0] r_rem_reg, r_rem_next;
    logic [26:0]           r_q_reg;

    logic [25:0] z_rise_reg, z_rise_next;
    logic [26:0] z_set_reg, z_set_next, z_now_reg, z_now_next;
    ssdn_pkg::out_t out_reg, out_next;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];
    assign m_data  = out_reg;

    // ---- front: day of year, latitude clamp, seconds of day ----
    always_comb begin
        logic [3:0]  mon;
        logic [9:0]  doy;
        logic signed [10:0] t;
        mon = s_data.month;
        if (mon == 4'd0) begin
            mon = 4'd1;
        end else if (mon > 4'd12) begin
            mon = 4'd12;
        end
        doy = 10'(ssdn_pkg::days_before(mon - 4'd1)) + 10'(s_data.day_of_month);
        t = $signed({1'b0, doy}) - 11'(ssdn_pkg::EQUINOX_DOY);
        s0_neg_next = t[10];
        s0_m_next   = t[10] ? 9'(-t) : 9'(t);
        if (lat_cfg_reg > 15'(ssdn_pkg::LAT_LIMIT)) begin
            s0_lat_next = 15'(ssdn_pkg::LAT_LIMIT);
        end else if (lat_cfg_reg < -15'(ssdn_pkg::LAT_LIMIT)) begin
            s0_lat_next = -15'(ssdn_pkg::LAT_LIMIT);
        end else begin
            s0_lat_next = lat_cfg_reg;
        end
        sec_next = (17'(s_data.hour) * 17'd60 + 17'(s_data.minute)) * 17'd60
                 + 17'(s_data.second);
    end

    always_comb begin
        longint mag, lv;
        longint arg;
        s1_p_next    = 34'(longint'(s0_m_reg) * ssdn_pkg::DEC_STEP_Q);
        s1_x_next    = 15'(s0_m_reg) * 15'(ssdn_pkg::DEC_STEP_R);
        s1_latp_next = 33'(longint'(s0_lat_reg) * ssdn_pkg::CENTIDEG_Q30);

        mag = longint'(s1_p_reg)
            + ((longint'(s1_x_reg) * ssdn_pkg::RECIP_365) >>> ssdn_pkg::RECIP_SHIFT);
        s2_mag_next = 34'(mag);
        lv = longint'(s1_latp_reg);
        s2_lat_next = AW'(ssdn_pkg::to_f(lv));

        // fold the argument into [-pi/2, pi/2]; late December needs both steps
        arg = s2_neg_reg ? -longint'(s2_mag_reg) : longint'(s2_mag_reg);
        if (arg > ssdn_pkg::HALF_PI_Q30) begin
            arg = ssdn_pkg::PI_Q30 - arg;
        end
        if (arg < -ssdn_pkg::HALF_PI_Q30) begin
            arg = -ssdn_pkg::PI_Q30 - arg;
        end
        s3_ang_next = AW'(ssdn_pkg::to_f(arg));
    end

    // ---- rotation CORDIC, two lanes ----
    always_comb begin
        logic signed [AW-1:0] a;
        for (int i = 1; i <= IT; i++) begin
            a = ssdn_pkg::atan_f(i - 1);
            if (!az_reg[i-1][AW-1]) begin
                ax_next[i] = ax_reg[i-1] - (ay_reg[i-1] >>> (i - 1));
                ay_next[i] = ay_reg[i-1] + (ax_reg[i-1] >>> (i - 1));
                az_next[i] = az_reg[i-1] - a;
            end else begin
                ax_next[i] = ax_reg[i-1] + (ay_reg[i-1] >>> (i - 1));
                ay_next[i] = ay_reg[i-1] - (ax_reg[i-1] >>> (i - 1));
                az_next[i] = az_reg[i-1] + a;
            end
            if (!bz_reg[i-1][AW-1]) begin
                bx_next[i] = bx_reg[i-1] - (by_reg[i-1] >>> (i - 1));
                by_next[i] = by_reg[i-1] + (bx_reg[i-1] >>> (i - 1));
                bz_next[i] = bz_reg[i-1] - a;
            end else begin
                bx_next[i] = bx_reg[i-1] + (by_reg[i-1] >>> (i - 1));
                by_next[i] = by_reg[i-1] - (bx_reg[i-1] >>> (i - 1));
                bz_next[i] = bz_reg[i-1] + a;
            end
        end
    end

    always_comb begin
        dec_next = AW'(ssdn_pkg::asr_rnd(ssdn_pkg::TILT_Q30 * longint'(ay_reg[IT]), 30));
        cl_next  = bx_reg[IT][AW-1] ? '0 : bx_reg[IT];
    end

    always_comb begin
        logic signed [AW-1:0] a;
        for (int i = 1; i <= IT; i++) begin
            a = ssdn_pkg::atan_f(i - 1);
            if (!cz_reg[i-1][AW-1]) begin
                cx_next[i] = cx_reg[i-1] - (cy_reg[i-1] >>> (i - 1));
                cy_next[i] = cy_reg[i-1] + (cx_reg[i-1] >>> (i - 1));
                cz_next[i] = cz_reg[i-1] - a;
            end else begin
                cx_next[i] = cx_reg[i-1] + (cy_reg[i-1] >>> (i - 1));
                cy_next[i] = cy_reg[i-1] - (cx_reg[i-1] >>> (i - 1));
                cz_next[i] = cz_reg[i-1] + a;
            end
        end
    end

    // ---- N, D and the ratio classification ----
    always_comb begin
        logic signed [AW-1:0] cd;
        logic signed [AW-1:0] an;
        cd = cx_reg[IT][AW-1] ? '0 : cx_reg[IT];
        f_n_next = AW'(-ssdn_pkg::asr_rnd(longint'(csl_reg[IT]) * longint'(cy_reg[IT]), FB));
        f_d_next = AW'(ssdn_pkg::asr_rnd(longint'(ccl_reg[IT]) * longint'(cd), FB));

        g_d2_next = RW'(longint'(f_d_reg) * longint'(f_d_reg));
        g_n2_next = RW'(longint'(f_n_reg) * longint'(f_n_reg));
        an = f_n_reg[AW-1] ? -f_n_reg : f_n_reg;
        if (f_n_reg == '0) begin
            g_sel_next = SEL_HALF;
        end else if (an >= f_d_reg) begin
            g_sel_next = f_n_reg[AW-1] ? SEL_PI : SEL_ZERO;
        end else begin
            g_sel_next = SEL_CALC;
        end
    end

    // ---- floor square root, one result bit per stage ----
    always_comb begin
        logic [RW-1:0] bitv, tmp;
        for (int i = 1; i <= AW; i++) begin
            bitv = RW'(1) << (RW - 2 - 2 * (i - 1));
            tmp  = qs_reg[i-1] + bitv;
            if (qr_reg[i-1] >= tmp) begin
                qr_next[i] = qr_reg[i-1] - tmp;
                qs_next[i] = (qs_reg[i-1] >> 1) + bitv;
            end else begin
                qr_next[i] = qr_reg[i-1];
                qs_next[i] = qs_reg[i-1] >> 1;
            end
        end
    end

    // ---- vectoring CORDIC: atan2(root, N) ----
    always_comb begin
        logic signed [AW-1:0] root;
        root = AW'(qs_reg[AW]);
        if (qn_reg[AW][AW-1]) begin
            v0x_next = root;
            v0y_next = -qn_reg[AW];
            v0z_next = AW'(ssdn_pkg::HALF_PI_F);
        end else begin
            v0x_next = qn_reg[AW];
            v0y_next = root;
            v0z_next = '0;
        end
    end

    always_comb begin
        logic signed [AW-1:0] a;
        for (int i = 1; i <= IT; i++) begin
            a = ssdn_pkg::atan_f(i - 1);
            if (!vy_reg[i-1][AW-1]) begin
                vx_next[i] = vx_reg[i-1] + (vy_reg[i-1] >>> (i - 1));
                vy_next[i] = vy_reg[i-1] - (vx_reg[i-1] >>> (i - 1));
                vz_next[i] = vz_reg[i-1] + a;
            end else begin
                vx_next[i] = vx_reg[i-1] - (vy_reg[i-1] >>> (i - 1));
                vy_next[i] = vy_reg[i-1] + (vx_reg[i-1] >>> (i - 1));
                vz_next[i] = vz_reg[i-1] - a;
            end
        end
    end

    always_comb begin
        logic signed [AW-1:0] hv;
        case (vsel_reg[IT])
            SEL_HALF: hv = AW'(ssdn_pkg::HALF_PI_F);
            SEL_ZERO: hv = '0;
            SEL_PI:   hv = AW'(ssdn_pkg::PI_F);
            default:  hv = vz_reg[IT];
        endcase
        if (hv[AW-1]) begin
            h_next = '0;
        end else if (hv > AW'(ssdn_pkg::PI_F)) begin
            h_next = HW'(ssdn_pkg::PI_F);
        end else begin
            h_next = HW'(hv);
        end
    end

    // ---- offset: estimate within one of the rounded quotient, remainder fixes it ----
    always_comb begin
        e_q_next   = 27'((longint'(h_reg) * ssdn_pkg::OFF_RECIP
                         + (64'sd1 <<< (ssdn_pkg::OFF_SHIFT - 1))) >>> ssdn_pkg::OFF_SHIFT);
        r_rem_next = RMW'(longint'(e_h_reg) * ssdn_pkg::NOON_MS + ssdn_pkg::PI_F / 2
                          - longint'(e_q_reg) * ssdn_pkg::PI_F);
    end

    always_comb begin
        logic [26:0] off;
        logic signed [28:0] rise, set, now, wait_ms;
        if (r_rem_reg[RMW-1]) begin
            off = r_q_reg - 27'd1;
        end else if (r_rem_reg >= RMW'(ssdn_pkg::PI_F)) begin
            off = r_q_reg + 27'd1;
        end else begin
            off = r_q_reg;
        end
        if (off > 27'(ssdn_pkg::NOON_MS)) begin
            off = 27'(ssdn_pkg::NOON_MS);
        end
        z_rise_next = 26'(27'(ssdn_pkg::NOON_MS) - off);
        z_set_next  = 27'(ssdn_pkg::NOON_MS) + off;
        z_now_next  = 27'(sec_reg[LAT-3]) * 27'(ssdn_pkg::MS_PER_S);

        rise = 29'(z_rise_reg);
        set  = 29'(z_set_reg);
        now  = 29'(z_now_reg);
        if (now < rise) begin
            wait_ms = rise - now;
        end else if (now < set) begin
            wait_ms = set - now;
        end else begin
            wait_ms = rise + 29'(ssdn_pkg::DAY_MS) - now;
        end
        if (wait_ms[28]) begin
            wait_ms = '0;
        end
        out_next.is_day            = (now >= rise) && (now <= set);
        out_next.sunrise_ms        = z_rise_reg;
        out_next.sunset_ms         = z_set_reg;
        out_next.ms_to_next_switch = 27'(wait_ms);
    end

    // ---- control ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            lat_cfg_reg <= 15'(ssdn_pkg::LAT_RESET);
        end else begin
            if (cfg_we) begin
                lat_cfg_reg <= cfg_wdata;
            end
            if (adv) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge aclk) begin
        if (adv) begin
            sec_reg[0] <= sec_next;
            for (int k = 1; k <= LAT - 3; k++) begin
                sec_reg[k] <= sec_reg[k-1];
            end
            s0_m_reg    <= s0_m_next;
            s0_neg_reg  <= s0_neg_next;
            s0_lat_reg  <= s0_lat_next;
            s1_p_reg    <= s1_p_next;
            s1_x_reg    <= s1_x_next;
            s1_latp_reg <= s1_latp_next;
            s1_neg_reg  <= s0_neg_reg;
            s2_mag_reg  <= s2_mag_next;
            s2_lat_reg  <= s2_lat_next;
            s2_neg_reg  <= s1_neg_reg;

            ax_reg[0] <= AW'(ssdn_pkg::GAIN_F);
            ay_reg[0] <= '0;
            az_reg[0] <= s3_ang_next;
            bx_reg[0] <= AW'(ssdn_pkg::GAIN_F);
            by_reg[0] <= '0;
            bz_reg[0] <= s2_lat_reg;
            cx_reg[0]  <= AW'(ssdn_pkg::GAIN_F);
            cy_reg[0]  <= '0;
            cz_reg[0]  <= dec_next;
            ccl_reg[0] <= cl_next;
            csl_reg[0] <= by_reg[IT];
            for (int i = 1; i <= IT; i++) begin
                ax_reg[i]  <= ax_next[i];
                ay_reg[i]  <= ay_next[i];
                az_reg[i]  <= az_next[i];
                bx_reg[i]  <= bx_next[i];
                by_reg[i]  <= by_next[i];
                bz_reg[i]  <= bz_next[i];
                cx_reg[i]  <= cx_next[i];
                cy_reg[i]  <= cy_next[i];
                cz_reg[i]  <= cz_next[i];
                ccl_reg[i] <= ccl_reg[i-1];
                csl_reg[i] <= csl_reg[i-1];
            end

            f_n_reg   <= f_n_next;
            f_d_reg   <= f_d_next;
            g_d2_reg  <= g_d2_next;
            g_n2_reg  <= g_n2_next;
            g_n_reg   <= f_n_reg;
            g_sel_reg <= g_sel_next;

            qr_reg[0]   <= g_d2_reg - g_n2_reg;
            qs_reg[0]   <= '0;
            qn_reg[0]   <= g_n_reg;
            qsel_reg[0] <= g_sel_reg;
            for (int i = 1; i <= AW; i++) begin
                qr_reg[i]   <= qr_next[i];
                qs_reg[i]   <= qs_next[i];
                qn_reg[i]   <= qn_reg[i-1];
                qsel_reg[i] <= qsel_reg[i-1];
            end

            vx_reg[0]   <= v0x_next;
            vy_reg[0]   <= v0y_next;
            vz_reg[0]   <= v0z_next;
            vsel_reg[0] <= qsel_reg[AW];
            for (int i = 1; i <= IT; i++) begin
                vx_reg[i]   <= vx_next[i];
                vy_reg[i]   <= vy_next[i];
                vz_reg[i]   <= vz_next[i];
                vsel_reg[i] <= vsel_reg[i-1];
            end

            h_reg <= h_next;

            e_q_reg   <= e_q_next;
            e_h_reg   <= h_reg;
            r_rem_reg <= r_rem_next;
            r_q_reg   <= e_q_reg;

            z_rise_reg <= z_rise_next;
            z_set_reg  <= z_set_next;
            z_now_reg  <= z_now_next;
            out_reg    <= out_next;
        end
    end

endmodule

// ----- tb/tb_sunrise_sunset_day_night.sv -----
// Self-checking testbench for the sunrise/sunset day-night pipeline.
`timescale 1ns / 1ps

module tb_sunrise_sunset_day_night;

    localparam int DRAIN_CYCLES = 250;
    localparam int STALL_LIMIT  = 20000;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   cfg_we = 1'b0;
    logic signed [14:0] cfg_wdata = '0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    ssdn_pkg::in_t  s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    ssdn_pkg::out_t m_data;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     errors = 0;
    int     queries_sent = 0;
    int     results_seen = 0;
    int     stall_cycles = 0;
    int     day_count = 0;
    int     polar_count = 0;
    longint model_lat = ssdn_pkg::LAT_RESET;
    ssdn_pkg::out_t sun_expected[$];

    longint day_ms_table [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    sunrise_sunset_day_night uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic longint q30_to_angle(input longint v);
        longint r;
        if (ssdn_pkg::ANG_SHIFT == 0) begin
            r = v;
        end else begin
            r = (v + (64'sd1 <<< (ssdn_pkg::ANG_SHIFT - 1))) >>> ssdn_pkg::ANG_SHIFT;
        end
        return r;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (ssdn_pkg::ANGLE_FRAC_BITS - 1)))
               >>> ssdn_pkg::ANGLE_FRAC_BITS;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bv;
        res = 0;
        bv = 64'd1 << 62;
        while (bv > n) bv = bv >> 2;
        while (bv != 0) begin
            if (n >= res + bv) begin
                n = n - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic void rotate_angle(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy, a;
        x = q30_to_angle(ssdn_pkg::GAIN_INV_Q30);
        y = 0;
        z = ang;
        for (int i = 0; i < ssdn_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            a = q30_to_angle(ssdn_pkg::ATAN_Q30[i]);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - a;
            end else begin
                x = x + dx; y = y - dy; z = z + a;
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_angle(input longint xi, input longint yi);
        longint x, y, z, t, dx, dy, a;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = q30_to_angle(ssdn_pkg::HALF_PI_Q30);
        end
        for (int i = 0; i < ssdn_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            a = q30_to_angle(ssdn_pkg::ATAN_Q30[i]);
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + a;
            end else begin
                x = x - dx; y = y + dy; z = z - a;
            end
        end
        return z;
    endfunction

    function automatic ssdn_pkg::out_t predict_sun_times(input ssdn_pkg::in_t q,
                                                         input longint lat_reg);
        ssdn_pkg::out_t r;
        longint pi_f, mon, doy, arg, cx, sx, dec, lat, cl, sl, cd, sd;
        longint n, d, an, h, off, rise, set_t, now_t, wait_t;
        pi_f = q30_to_angle(ssdn_pkg::PI_Q30);
        mon = q.month;
        if (mon < 1) mon = 1;
        if (mon > 12) mon = 12;
        doy = day_ms_table[mon - 1] + longint'(q.day_of_month);
        arg = ((doy - ssdn_pkg::EQUINOX_DOY) * 2 * ssdn_pkg::PI_Q30) / 365;
        if (arg > ssdn_pkg::HALF_PI_Q30) arg = ssdn_pkg::PI_Q30 - arg;
        if (arg < -ssdn_pkg::HALF_PI_Q30) arg = -ssdn_pkg::PI_Q30 - arg;
        rotate_angle(q30_to_angle(arg), cx, sx);
        dec = (ssdn_pkg::TILT_Q30 * sx + (64'sd1 <<< 29)) >>> 30;
        lat = lat_reg;
        if (lat > ssdn_pkg::LAT_LIMIT) lat = ssdn_pkg::LAT_LIMIT;
        if (lat < -ssdn_pkg::LAT_LIMIT) lat = -ssdn_pkg::LAT_LIMIT;
        rotate_angle(q30_to_angle(lat * ssdn_pkg::CENTIDEG_Q30), cl, sl);
        rotate_angle(dec, cd, sd);
        if (cl < 0) cl = 0;
        if (cd < 0) cd = 0;
        n = -fmul(sl, sd);
        d = fmul(cl, cd);
        an = (n < 0) ? -n : n;
        if (n == 0) begin
            h = q30_to_angle(ssdn_pkg::HALF_PI_Q30);
        end else if (an >= d) begin
            h = (n > 0) ? 0 : pi_f;
        end else begin
            h = vector_angle(n, floor_sqrt(longint'(d * d - n * n)));
        end
        if (h < 0) h = 0;
        if (h > pi_f) h = pi_f;
        off = (h * ssdn_pkg::NOON_MS + pi_f / 2) / pi_f;
        if (off > ssdn_pkg::NOON_MS) off = ssdn_pkg::NOON_MS;
        rise = ssdn_pkg::NOON_MS - off;
        set_t = ssdn_pkg::NOON_MS + off;
        now_t = ((longint'(q.hour) * 60 + longint'(q.minute)) * 60 + longint'(q.second))
                * ssdn_pkg::MS_PER_S;
        if (now_t < rise) wait_t = rise - now_t;
        else if (now_t < set_t) wait_t = set_t - now_t;
        else wait_t = rise + ssdn_pkg::DAY_MS - now_t;
        if (wait_t < 0) wait_t = 0;
        r.is_day = (now_t >= rise && now_t <= set_t);
        r.sunrise_ms = rise[25:0];
        r.sunset_ms = set_t[26:0];
        r.ms_to_next_switch = wait_t[26:0];
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        ssdn_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (sun_expected.size() == 0) begin
                report_mismatch("transactions outstanding", 0, 1);
            end else begin
                want = sun_expected.pop_front();
                if (m_data.is_day != want.is_day)
                    report_mismatch("is_day", m_data.is_day, want.is_day);
                if (m_data.sunrise_ms != want.sunrise_ms)
                    report_mismatch("sunrise_ms", m_data.sunrise_ms, want.sunrise_ms);
                if (m_data.sunset_ms != want.sunset_ms)
                    report_mismatch("sunset_ms", m_data.sunset_ms, want.sunset_ms);
                if (m_data.ms_to_next_switch != want.ms_to_next_switch)
                    report_mismatch("ms_to_next_switch", m_data.ms_to_next_switch,
                                    want.ms_to_next_switch);
            end
        end
    end

    // Watchdog: any transaction on either channel resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", sun_expected.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    // Entered and left just after a falling edge.
    task automatic send_query(input ssdn_pkg::in_t q);
        ssdn_pkg::out_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        want = predict_sun_times(q, model_lat);
        do @(posedge aclk); while (!s_ready);
        sun_expected.push_back(want);
        queries_sent++;
        if (want.is_day) day_count++;
        if (want.sunrise_ms == 0 || want.sunrise_ms == ssdn_pkg::NOON_MS) polar_count++;
        @(negedge aclk);
    endtask

    task automatic send_fields(input int mo, input int dy, input int hr, input int mi,
                               input int se);
        ssdn_pkg::in_t q;
        q.month = 4'(mo);
        q.day_of_month = 5'(dy);
        q.hour = 5'(hr);
        q.minute = 6'(mi);
        q.second = 6'(se);
        send_query(q);
    endtask

    task automatic set_latitude(input int v);
        s_valid <= 1'b0;
        while (sun_expected.size() != 0) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= 15'(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        model_lat = longint'($signed(cfg_wdata));
    endtask

    function automatic ssdn_pkg::in_t random_query();
        ssdn_pkg::in_t q;
        if ($urandom_range(99) < 85) begin
            q.month = 4'($urandom_range(12, 1));
            q.day_of_month = 5'($urandom_range(31, 1));
            q.hour = 5'($urandom_range(23, 0));
            q.minute = 6'($urandom_range(59, 0));
            q.second = 6'($urandom_range(59, 0));
        end else begin
            q = 26'($urandom);
        end
        return q;
    endfunction

    task automatic test_directed();
        send_fields(1, 1, 0, 0, 0);
        send_fields(12, 31, 23, 59, 59);
        send_fields(3, 21, 12, 0, 0);      // equinox
        send_fields(6, 21, 5, 0, 0);       // summer solstice
        send_fields(12, 21, 17, 30, 0);    // winter solstice
        send_fields(0, 15, 6, 30, 0);      // month zero
        send_fields(13, 15, 18, 0, 0);
        send_fields(15, 31, 31, 63, 63);   // every field at its all-ones value
        send_fields(2, 0, 12, 0, 0);       // day zero
        send_fields(2, 31, 9, 15, 30);     // day past month length
        send_fields(7, 4, 24, 0, 0);
        send_fields(9, 10, 23, 63, 63);
        send_fields(4, 1, 0, 0, 1);
    endtask

    task automatic test_latitude_extremes();
        int lats [0:5] = '{9000, -9000, 16383, -16384, 0, 6650};
        foreach (lats[k]) begin
            set_latitude(lats[k]);
            send_fields(6, 21, 12, 0, 0);
            send_fields(12, 21, 0, 0, 0);
            send_fields(3, 21, 6, 0, 0);
            send_fields(9, 23, 23, 59, 59);
        end
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int per_lat);
        int lats [0:3];
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        lats[0] = $urandom_range(18000) - 9000;
        lats[1] = $urandom_range(32767) - 16384;
        lats[2] = ($urandom_range(1)) ? 8990 : -8990;
        lats[3] = ssdn_pkg::LAT_RESET;
        foreach (lats[k]) begin
            set_latitude(lats[k]);
            for (int i = 0; i < per_lat; i++) send_query(random_query());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_latitude_extremes();
        test_random_phase(30, 67, 115);
        test_random_phase(67, 30, 115);
        test_random_phase(0, 0, 115);
        s_valid <= 1'b0;
        while (sun_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("%0d queries, %0d results, %0d in daylight, %0d at polar day or night",
                 queries_sent, results_seen, day_count, polar_count);
        $display("latitudes swept over both poles, saturation and equator; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
